[hdl/voi_pkg.sv]
// voi_pkg: shared constants and controller/datapath interface types
// for the voxel octree insert core. No dependencies.
`default_nettype none

package voi_pkg;

	// node word layout: solid bit, eight child flags, child block base above
	localparam int SOLID_POS   = 0;
	localparam int FLAG_LSB    = 1;
	localparam int CHILD_LSB   = 9;
	localparam int BLOCK_NODES = 8;
	localparam int ROOT_INDEX  = 1;
	localparam int OCT_W       = 3;

	localparam int COORD_W      = 12;
	localparam int CFG_W        = 4;
	localparam int LEAF_W       = 12;
	localparam int USED_W       = 13;
	localparam int BLOCKS_W     = 4;
	localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd10;

	typedef struct packed {
		logic accept;   // latch coordinates, issue root read
		logic capture;  // take node word from read port
		logic step;     // update parent, move to child
		logic finish;   // write back current node, post result
	} voi_cmd_t;

	typedef struct packed {
		logic last;       // no levels left
		logic pool_full;  // block needed but pool exhausted
	} voi_status_t;

endpackage

`default_nettype wire

[hdl/voi_ctrl.sv]
// voi_ctrl: sequencing state machine for the octree insert.
// Depends on voi_pkg for the command and status structs.
`default_nettype none

module voi_ctrl
	import voi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire voi_status_t status,
	output voi_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CAPT = 2'd1;
	localparam logic [1:0] ST_STEP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_CAPT;
				end
			end
			ST_CAPT: begin
				cmd.capture = 1'b1;
				state_d     = ST_STEP;
			end
			ST_STEP: begin
				if (status.last || status.pool_full) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_CAPT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[hdl/voi_datapath.sv]
// voi_datapath: node memory, descent registers, allocator and result
// registers for the octree insert. Depends on voi_pkg.
`default_nettype none

module voi_datapath
	import voi_pkg::*;
#(
	parameter int POOL_NODES = 4096,
	parameter int MAX_LEVELS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire voi_cmd_t            cmd,
	output voi_status_t              status,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic [COORD_W-1:0]  coord_x,
	input  wire logic [COORD_W-1:0]  coord_y,
	input  wire logic [COORD_W-1:0]  coord_z,
	output logic                     result_valid,
	output logic [LEAF_W-1:0]        leaf_index,
	output logic [USED_W-1:0]        nodes_used,
	output logic [BLOCKS_W-1:0]      blocks_added,
	output logic                     overflow
);

	localparam int IDX_W  = $clog2(POOL_NODES);
	localparam int NF_W   = IDX_W + 1;
	localparam int NODE_W = CHILD_LSB + IDX_W;
	localparam int LV_W   = $clog2(MAX_LEVELS + 1);
	localparam int BIT_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int CRD_W  = (MAX_LEVELS > COORD_W) ? MAX_LEVELS : COORD_W;

	// node memory: one write and one registered read per cycle
	logic [NODE_W-1:0] mem [POOL_NODES];
	logic [NODE_W-1:0] rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [NODE_W-1:0] wr_data;
	logic              wr_en;

	logic [CFG_W-1:0]      levels_cfg_q;
	logic [MAX_LEVELS-1:0] cx_q, cy_q, cz_q;
	logic [LV_W-1:0]       lvl_q;
	logic [IDX_W-1:0]      cur_idx_q;
	logic [NODE_W-1:0]     cur_node_q;
	logic                  hit_q;
	logic                  root_valid_q;
	logic [NF_W-1:0]       next_free_q;
	logic [BLOCKS_W-1:0]   blocks_q;
	logic                  result_valid_q;
	logic [LEAF_W-1:0]     leaf_q;
	logic [USED_W-1:0]     used_q;
	logic [BLOCKS_W-1:0]   blocks_out_q;
	logic                  ovf_q;

	// level clamp and coordinate saturation at accept
	logic [LV_W-1:0]   levels;
	logic [CRD_W:0]    lim;
	logic [CRD_W-1:0]  ex, ey, ez;
	logic [CRD_W-1:0]  sx, sy, sz;

	always_comb begin
		if (levels_cfg_q == '0) begin
			levels = LV_W'(1);
		end else if (int'(levels_cfg_q) > MAX_LEVELS) begin
			levels = LV_W'(MAX_LEVELS);
		end else begin
			levels = LV_W'(levels_cfg_q);
		end
		lim = ((CRD_W+1)'(1) << levels) - (CRD_W+1)'(1);
		ex  = CRD_W'(coord_x);
		ey  = CRD_W'(coord_y);
		ez  = CRD_W'(coord_z);
		sx  = ({1'b0, ex} > lim) ? lim[CRD_W-1:0] : ex;
		sy  = ({1'b0, ey} > lim) ? lim[CRD_W-1:0] : ey;
		sz  = ({1'b0, ez} > lim) ? lim[CRD_W-1:0] : ez;
	end

	// one descent level
	logic [BIT_W-1:0]  bsel;
	logic [OCT_W-1:0]  oct;
	logic [IDX_W-1:0]  base;
	logic              need_blk;
	logic              full;
	logic [IDX_W-1:0]  new_base;
	logic [IDX_W-1:0]  cidx;
	logic [NODE_W-1:0] parent_new;
	logic              hit_d;

	always_comb begin
		bsel     = BIT_W'(lvl_q - LV_W'(1));
		oct      = {cz_q[bsel], cy_q[bsel], cx_q[bsel]};
		base     = cur_node_q[NODE_W-1:CHILD_LSB];
		need_blk = (base == '0);
		full     = ({1'b0, next_free_q} + (NF_W+1)'(BLOCK_NODES)) > (NF_W+1)'(POOL_NODES);
		new_base = need_blk ? next_free_q[IDX_W-1:0] : base;
		cidx     = new_base + IDX_W'(oct);
		parent_new = cur_node_q;
		parent_new[NODE_W-1:CHILD_LSB] = new_base;
		parent_new[FLAG_LSB + int'(oct)] = 1'b1;
		// a child with its flag clear was never written since its block was handed out
		hit_d = !need_blk && cur_node_q[FLAG_LSB + int'(oct)];
	end

	assign status.last      = (lvl_q == '0);
	assign status.pool_full = need_blk && full;

	always_comb begin
		rd_addr = cidx;
		if (cmd.accept) begin
			rd_addr = IDX_W'(ROOT_INDEX);
		end
		wr_en   = cmd.step || cmd.finish;
		wr_addr = cur_idx_q;
		wr_data = cmd.step ? parent_new : cur_node_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// descent registers carry no reset
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cx_q      <= sx[MAX_LEVELS-1:0];
			cy_q      <= sy[MAX_LEVELS-1:0];
			cz_q      <= sz[MAX_LEVELS-1:0];
			lvl_q     <= levels;
			cur_idx_q <= IDX_W'(ROOT_INDEX);
			hit_q     <= root_valid_q;
			blocks_q  <= '0;
		end
		if (cmd.capture) begin
			cur_node_q <= (hit_q ? rd_q : '0) | NODE_W'(1 << SOLID_POS);
		end
		if (cmd.step) begin
			cur_idx_q <= cidx;
			hit_q     <= hit_d;
			lvl_q     <= lvl_q - LV_W'(1);
			if (need_blk) begin
				blocks_q <= blocks_q + BLOCKS_W'(1);
			end
		end
	end

	logic [IDX_W+LEAF_W-1:0] leaf_ext;
	logic [NF_W+USED_W-1:0]  used_ext;

	assign leaf_ext = {{LEAF_W{1'b0}}, cur_idx_q};
	assign used_ext = {{USED_W{1'b0}}, next_free_q};

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			leaf_q       <= leaf_ext[LEAF_W-1:0];
			used_q       <= used_ext[USED_W-1:0];
			blocks_out_q <= blocks_q;
			ovf_q        <= !status.last && status.pool_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_cfg_q   <= LEVELS_RESET;
			next_free_q    <= NF_W'(BLOCK_NODES);
			root_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				levels_cfg_q <= cfg_data;
			end
			if (cmd.step && need_blk) begin
				next_free_q <= next_free_q + NF_W'(BLOCK_NODES);
			end
			if (wr_en && (wr_addr == IDX_W'(ROOT_INDEX))) begin
				root_valid_q <= 1'b1;
			end
			result_valid_q <= cmd.finish;
		end
	end

	assign result_valid = result_valid_q;
	assign leaf_index   = leaf_q;
	assign nodes_used   = used_q;
	assign blocks_added = blocks_out_q;
	assign overflow     = ovf_q;

endmodule

`default_nettype wire

[hdl/voxel_octree_insert_core.sv]
// voxel_octree_insert_core: top level of the sparse voxel octree insert.
// Instantiates voi_ctrl and voi_datapath; depends on voi_pkg.
//
// Usage:
//   Command channel: drive coord_x/y/z and raise start; the insert is taken
//   at a rising edge with start high and busy low. busy stays high until
//   the insert has finished its walk.
//   Config channel: cfg_data (levels per insert) is written on an edge with
//   cfg_valid and cfg_ready high; cfg_ready is high while the core is idle.
//   Result: leaf_index, nodes_used, blocks_added and overflow are valid for
//   exactly one cycle while result_valid is high; the receiver cannot stall,
//   so it must take the result in that cycle.
//   Timing: result_valid rises in the cycle busy falls, and a new insert is
//   taken only once busy is low again. Each level costs a node memory read
//   of the child and a write of the updated parent; the registered read
//   port splits each level into a capture state and a step state.
//   Reset: clears the level register to 10, the allocator to the first
//   free block and the root valid bit; no memory clearing pass is needed,
//   a node reads as empty until its parent flags it, the root until written.
`default_nettype none

module voxel_octree_insert_core
	import voi_pkg::*;
#(
	parameter int POOL_NODES = 4096,
	parameter int MAX_LEVELS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [COORD_W-1:0]  coord_x,
	input  wire logic [COORD_W-1:0]  coord_y,
	input  wire logic [COORD_W-1:0]  coord_z,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data,
	output logic                     result_valid,
	output logic [LEAF_W-1:0]        leaf_index,
	output logic [USED_W-1:0]        nodes_used,
	output logic [BLOCKS_W-1:0]      blocks_added,
	output logic                     overflow
);

	voi_cmd_t    cmd;
	voi_status_t status;

	assign cfg_ready = !busy;

	voi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	voi_datapath #(
		.POOL_NODES (POOL_NODES),
		.MAX_LEVELS (MAX_LEVELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.result_valid (result_valid),
		.leaf_index   (leaf_index),
		.nodes_used   (nodes_used),
		.blocks_added (blocks_added),
		.overflow     (overflow)
	);

endmodule

`default_nettype wire
